// ===== rtl/core/lbm_pkg.sv =====
// Shared types, codes and constants of the link bring-up monitor.
// No dependencies; used by lbm_front, lbm_back and the top level.
package lbm_pkg;

	localparam int NOW_W   = 48;
	localparam int TO_W    = 32;
	localparam int LIMIT_W = 8;
	localparam int ADDR_W  = 32;
	localparam int CFG_W   = 48;
	localparam int CFG_IDX_W = 2;

	localparam int TIME_BITS_DEF   = 48;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [NOW_W-1:0]   START_TIME_RST = '0;
	localparam logic [TO_W-1:0]    START_TO_RST   = 32'd10000;
	localparam logic [TO_W-1:0]    TOTAL_TO_RST   = 32'd30000;
	localparam logic [LIMIT_W-1:0] NF_LIMIT_RST   = 8'd3;
	localparam logic [LIMIT_W-1:0] NF_MAX         = 8'd255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TO   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NF_LIMIT   = 2'd3;

	// item ops
	localparam logic [1:0] OP_RUNNING = 2'd0;
	localparam logic [1:0] OP_EVENT   = 2'd1;
	localparam logic [1:0] OP_STATUS  = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	// event kinds
	localparam logic [2:0] EV_OTHER     = 3'd0;
	localparam logic [2:0] EV_TEMP_DIS  = 3'd1;
	localparam logic [2:0] EV_PSK_FAIL  = 3'd2;
	localparam logic [2:0] EV_ASSOC_REJ = 3'd3;
	localparam logic [2:0] EV_AUTH_REJ  = 3'd4;
	localparam logic [2:0] EV_NOT_FOUND = 3'd5;
	localparam logic [2:0] EV_CONNECTED = 3'd6;
	localparam logic [2:0] EV_SCAN      = 3'd7;

	// temp-disabled reasons
	localparam logic [1:0] DR_OTHER     = 2'd0;
	localparam logic [1:0] DR_WRONG_KEY = 2'd1;
	localparam logic [1:0] DR_AUTH_FAIL = 2'd2;
	localparam logic [1:0] DR_CONN_FAIL = 2'd3;

	// supplicant states
	localparam logic [2:0] WS_OTHER     = 3'd0;
	localparam logic [2:0] WS_AUTH      = 3'd1;
	localparam logic [2:0] WS_ASSOCING  = 3'd2;
	localparam logic [2:0] WS_ASSOCED   = 3'd3;
	localparam logic [2:0] WS_FOUR_WAY  = 3'd4;
	localparam logic [2:0] WS_GROUP     = 3'd5;
	localparam logic [2:0] WS_COMPLETED = 3'd6;

	// output stage codes
	localparam logic [2:0] SC_STARTING   = 3'd0;
	localparam logic [2:0] SC_SEARCHING  = 3'd1;
	localparam logic [2:0] SC_ASSOCIATING = 3'd2;
	localparam logic [2:0] SC_HANDSHAKE  = 3'd3;
	localparam logic [2:0] SC_GETADDR    = 3'd4;
	localparam logic [2:0] SC_CONNECTED  = 3'd5;
	localparam logic [2:0] SC_FAILED     = 3'd6;

	typedef enum logic [6:0] {
		S_START   = 7'b0000001,
		S_SEARCH  = 7'b0000010,
		S_ASSOC   = 7'b0000100,
		S_HSHAKE  = 7'b0001000,
		S_GETADDR = 7'b0010000,
		S_CONN    = 7'b0100000,
		S_FAIL    = 7'b1000000
	} stage_t;

	typedef enum logic [2:0] {
		F_NONE      = 3'd0,
		F_NO_SUPP   = 3'd1,
		F_WRONG_PW  = 3'd2,
		F_NOT_FOUND = 3'd3,
		F_ASSOC_REJ = 3'd4,
		F_AUTH_REJ  = 3'd5,
		F_NO_ADDR   = 3'd6,
		F_TIMEOUT   = 3'd7
	} fail_t;

	typedef enum logic [1:0] {
		REJ_NONE  = 2'd0,
		REJ_ASSOC = 2'd1,
		REJ_AUTH  = 2'd2
	} rej_t;

	typedef enum logic [3:0] {
		CMD_TICK      = 4'd0,
		CMD_RUN_ON    = 4'd1,
		CMD_RUN_OFF   = 4'd2,
		CMD_FAIL      = 4'd3,
		CMD_REJ_ASSOC = 4'd4,
		CMD_REJ_AUTH  = 4'd5,
		CMD_NOT_FOUND = 4'd6,
		CMD_LINK_UP   = 4'd7,
		CMD_SCAN      = 4'd8,
		CMD_STATUS    = 4'd9
	} cmd_op_t;

	// classified word from front to back
	typedef struct packed {
		cmd_op_t             op;
		fail_t               fail;
		stage_t              tgt;
		logic                connect;
		logic [ADDR_W-1:0]   addr;
		logic                start_hit;
		logic                total_hit;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        stage;
		fail_t             failure;
		logic [ADDR_W-1:0] addr;
	} res_t;

	function automatic logic [2:0] stage_code(stage_t s);
		logic [2:0] c;
		case (s)
			S_START:   c = SC_STARTING;
			S_SEARCH:  c = SC_SEARCHING;
			S_ASSOC:   c = SC_ASSOCIATING;
			S_HSHAKE:  c = SC_HANDSHAKE;
			S_GETADDR: c = SC_GETADDR;
			S_CONN:    c = SC_CONNECTED;
			S_FAIL:    c = SC_FAILED;
			default:   c = SC_STARTING;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/lbm_fifo.sv =====
// Small flop-based queue used between front and back and on the result side.
// Depends on nothing; WIDTH and DEPTH set by the instantiating module.
module lbm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/lbm_front.sv =====
// Front end: accepts items, decodes them into command words and does the
// elapsed-time compares. Depends on lbm_pkg.
module lbm_front #(
	parameter int TIME_BITS = lbm_pkg::TIME_BITS_DEF
) (
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  op,
	input  logic [lbm_pkg::NOW_W-1:0]   now_ms,
	input  logic                        running,
	input  logic [2:0]                  event_kind,
	input  logic [1:0]                  disable_reason,
	input  logic [2:0]                  wpa_state,
	input  logic                        ssid_matches,
	input  logic                        address_valid,
	input  logic [lbm_pkg::ADDR_W-1:0]  address_in,
	input  logic [lbm_pkg::NOW_W-1:0]   start_time,
	input  logic [lbm_pkg::TO_W-1:0]    start_timeout_ms,
	input  logic [lbm_pkg::TO_W-1:0]    total_timeout_ms,
	input  logic                        q_full,
	output logic                        q_wr,
	output lbm_pkg::cmd_t               cmd
);
	import lbm_pkg::*;

	// timestamps are compared on the low TIME_BITS bits, capped at NOW_W
	localparam int TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
	localparam int CW = (TW > TO_W) ? TW : TO_W;

	logic [TW-1:0] now_m, t0_m, waited;
	logic [CW-1:0] waited_x;
	logic          late;
	stage_t        ws_stage;

	assign full = q_full;
	assign q_wr = push && !q_full;

	assign now_m    = now_ms[TW-1:0];
	assign t0_m     = start_time[TW-1:0];
	assign late     = (now_m >= t0_m);
	assign waited   = now_m - t0_m;
	assign waited_x = CW'(waited);

	always_comb begin
		case (wpa_state)
			WS_AUTH, WS_ASSOCING, WS_ASSOCED: ws_stage = S_ASSOC;
			WS_FOUR_WAY, WS_GROUP:            ws_stage = S_HSHAKE;
			WS_COMPLETED:                     ws_stage = ssid_matches ? S_GETADDR : S_ASSOC;
			default:                          ws_stage = S_SEARCH;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = CMD_TICK;
		cmd.fail      = F_NONE;
		cmd.tgt       = ws_stage;
		cmd.connect   = (ws_stage == S_GETADDR) && address_valid;
		cmd.addr      = address_in;
		cmd.start_hit = late && (waited_x >= CW'(start_timeout_ms));
		cmd.total_hit = late && (waited_x >= CW'(total_timeout_ms));
		case (op)
			OP_RUNNING: cmd.op = running ? CMD_RUN_ON : CMD_RUN_OFF;
			OP_STATUS:  cmd.op = CMD_STATUS;
			OP_EVENT: begin
				case (event_kind)
					EV_TEMP_DIS: begin
						case (disable_reason)
							DR_WRONG_KEY: begin
								cmd.op   = CMD_FAIL;
								cmd.fail = F_WRONG_PW;
							end
							DR_AUTH_FAIL: begin
								cmd.op   = CMD_FAIL;
								cmd.fail = F_AUTH_REJ;
							end
							DR_CONN_FAIL: begin
								cmd.op   = CMD_FAIL;
								cmd.fail = F_ASSOC_REJ;
							end
							default: cmd.op = CMD_TICK;
						endcase
					end
					EV_PSK_FAIL: begin
						cmd.op   = CMD_FAIL;
						cmd.fail = F_WRONG_PW;
					end
					EV_ASSOC_REJ: cmd.op = CMD_REJ_ASSOC;
					EV_AUTH_REJ:  cmd.op = CMD_REJ_AUTH;
					EV_NOT_FOUND: cmd.op = CMD_NOT_FOUND;
					EV_CONNECTED: cmd.op = CMD_LINK_UP;
					EV_SCAN:      cmd.op = CMD_SCAN;
					default:      cmd.op = CMD_TICK;
				endcase
			end
			default: cmd.op = CMD_TICK;
		endcase
	end

endmodule

// ===== rtl/core/lbm_back.sv =====
// Back end: holds the link state and applies one command word per cycle while the command
// queue is not empty and the result queue not full, producing one result word each. Depends on lbm_pkg.
module lbm_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lbm_pkg::cmd_t                cmd,
	input  logic                         cmd_empty,
	output logic                         cmd_pop,
	input  logic [lbm_pkg::LIMIT_W-1:0]  not_found_limit,
	input  logic                         res_full,
	output logic                         res_push,
	output lbm_pkg::res_t                res
);
	import lbm_pkg::*;

	stage_t               stage_q, stage_n, stage_a;
	fail_t                fail_q, fail_n;
	rej_t                 rej_q, rej_n;
	logic [LIMIT_W-1:0]   nf_cnt_q, nf_cnt_n;
	logic [ADDR_W-1:0]    held_q, held_n;
	logic                 done, chk, fire;

	assign done     = (stage_q == S_CONN) || (stage_q == S_FAIL);
	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;

	always_comb begin
		stage_a  = stage_q;
		stage_n  = stage_q;
		fail_n   = fail_q;
		rej_n    = rej_q;
		nf_cnt_n = nf_cnt_q;
		held_n   = held_q;
		chk      = 1'b0;
		if (!done) begin
			chk = 1'b1;
			case (cmd.op)
				CMD_RUN_ON: begin
					if (stage_q == S_START) begin
						stage_a = S_SEARCH;
					end
				end
				CMD_RUN_OFF: stage_a = S_START;
				CMD_FAIL: begin
					stage_a = S_FAIL;
					fail_n  = cmd.fail;
					chk     = 1'b0;
				end
				CMD_REJ_ASSOC: rej_n = REJ_ASSOC;
				CMD_REJ_AUTH:  rej_n = REJ_AUTH;
				CMD_NOT_FOUND: begin
					nf_cnt_n = (nf_cnt_q == NF_MAX) ? NF_MAX : nf_cnt_q + 1'b1;
					if (nf_cnt_n >= not_found_limit) begin
						stage_a = S_FAIL;
						fail_n  = F_NOT_FOUND;
						chk     = 1'b0;
					end
				end
				CMD_LINK_UP: stage_a = S_GETADDR;
				CMD_SCAN: begin
					if (stage_q == S_START) begin
						stage_a = S_SEARCH;
					end
				end
				CMD_STATUS: begin
					if (cmd.connect) begin
						held_n  = cmd.addr;
						stage_a = S_CONN;
						chk     = 1'b0;
					end else begin
						stage_a = cmd.tgt;
					end
				end
				default: ;
			endcase
			stage_n = stage_a;
			// timeout check runs on the stage this item moved the link to
			if (chk) begin
				if (cmd.start_hit && stage_a == S_START) begin
					stage_n = S_FAIL;
					fail_n  = F_NO_SUPP;
				end else if (cmd.total_hit) begin
					stage_n = S_FAIL;
					case (stage_a)
						S_GETADDR: fail_n = F_NO_ADDR;
						S_HSHAKE:  fail_n = F_WRONG_PW;
						default: begin
							if (rej_n == REJ_ASSOC) begin
								fail_n = F_ASSOC_REJ;
							end else if (rej_n == REJ_AUTH) begin
								fail_n = F_AUTH_REJ;
							end else if (stage_a == S_SEARCH) begin
								fail_n = F_NOT_FOUND;
							end else begin
								fail_n = F_TIMEOUT;
							end
						end
					endcase
				end
			end
		end
	end

	assign res.stage   = stage_code(stage_n);
	assign res.failure = fail_n;
	assign res.addr    = (stage_n == S_CONN) ? held_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= S_START;
			fail_q   <= F_NONE;
			rej_q    <= REJ_NONE;
			nf_cnt_q <= '0;
			held_q   <= '0;
		end else if (fire) begin
			stage_q  <= stage_n;
			fail_q   <= fail_n;
			rej_q    <= rej_n;
			nf_cnt_q <= nf_cnt_n;
			held_q   <= held_n;
		end
	end

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == S_FAIL |=> stage_q == S_FAIL && fail_q == $past(fail_q))
		else $error("failed stage left or reason changed");

	a_fail_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == S_FAIL) == (fail_q != F_NONE))
		else $error("failure reason out of step with stage");

	a_nf_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		nf_cnt_q >= $past(nf_cnt_q))
		else $error("not-found count went down");

	a_addr_only_conn: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q != S_CONN |-> held_q == '0)
		else $error("address held before connect");

endmodule

// ===== rtl/core/wifi_link_bringup_monitor.sv =====
// Link bring-up monitor top level: config registers, front end, command queue,
// back end and result queue. Depends on lbm_pkg, lbm_fifo, lbm_front, lbm_back.
// Flow: a pushed word enters the command queue, the back end applies it from its
//   head and writes the result word to the result queue and ports (empty low).
// Throughput: one word per cycle while not stalled by an empty or full queue.
// Reset (arst_n low): state, queues and config registers return to defaults.
module wifi_link_bringup_monitor #(
	parameter int TIME_BITS   = lbm_pkg::TIME_BITS_DEF,
	parameter int QUEUE_DEPTH = lbm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lbm_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [lbm_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     op,
	input  logic [lbm_pkg::NOW_W-1:0]      now_ms,
	input  logic                           running,
	input  logic [2:0]                     event_kind,
	input  logic [1:0]                     disable_reason,
	input  logic [2:0]                     wpa_state,
	input  logic                           ssid_matches,
	input  logic                           address_valid,
	input  logic [lbm_pkg::ADDR_W-1:0]     address_in,
	output logic                           empty,
	input  logic                           pop,
	output logic [2:0]                     stage,
	output logic [2:0]                     failure,
	output logic [lbm_pkg::ADDR_W-1:0]     address_out
);
	import lbm_pkg::*;

	logic [NOW_W-1:0]   start_time_q;
	logic [TO_W-1:0]    start_to_q;
	logic [TO_W-1:0]    total_to_q;
	logic [LIMIT_W-1:0] nf_limit_q;

	cmd_t cmd_in, cmd_out;
	res_t res_in, res_out;
	logic cmd_wr, cmd_full, cmd_empty, cmd_pop;
	logic res_push, res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= START_TIME_RST;
			start_to_q   <= START_TO_RST;
			total_to_q   <= TOTAL_TO_RST;
			nf_limit_q   <= NF_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_START_TIME: start_time_q <= cfg_wdata[NOW_W-1:0];
				REG_START_TO:   start_to_q   <= cfg_wdata[TO_W-1:0];
				REG_TOTAL_TO:   total_to_q   <= cfg_wdata[TO_W-1:0];
				REG_NF_LIMIT:   nf_limit_q   <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	lbm_front #(.TIME_BITS(TIME_BITS)) u_front (
		.push             (push),
		.full             (full),
		.op               (op),
		.now_ms           (now_ms),
		.running          (running),
		.event_kind       (event_kind),
		.disable_reason   (disable_reason),
		.wpa_state        (wpa_state),
		.ssid_matches     (ssid_matches),
		.address_valid    (address_valid),
		.address_in       (address_in),
		.start_time       (start_time_q),
		.start_timeout_ms (start_to_q),
		.total_timeout_ms (total_to_q),
		.q_full           (cmd_full),
		.q_wr             (cmd_wr),
		.cmd              (cmd_in)
	);

	lbm_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	lbm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd_out),
		.cmd_empty       (cmd_empty),
		.cmd_pop         (cmd_pop),
		.not_found_limit (nf_limit_q),
		.res_full        (res_full),
		.res_push        (res_push),
		.res             (res_in)
	);

	lbm_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_out),
		.full    (res_full),
		.empty   (empty)
	);

	assign stage       = res_out.stage;
	assign failure     = res_out.failure;
	assign address_out = res_out.addr;

endmodule
